// ----- hdl/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants
// Command, result kind and status codes plus parameter defaults.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int OWNER_BITS_DEF = 8;
  localparam int ID_W           = 5;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_KILL    = 2'd1,
    CMD_PROCESS = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_KILL  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BAD_ID = 2'd1,
    STS_FULL   = 2'd2
  } status_e;

endpackage

// ----- hdl/stt_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_cmd_if: command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface stt_cmd_if #(
  parameter int TIME_BITS  = stt_pkg::TIME_BITS_DEF,
  parameter int OWNER_BITS = stt_pkg::OWNER_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [TIME_BITS-1:0]    now;
  logic [TIME_BITS-1:0]    interval;
  logic                    repeat_req;
  logic [OWNER_BITS-1:0]   owner;
  logic [stt_pkg::ID_W-1:0] timer_id;

  modport source (
    output valid, command, now, interval, repeat_req, owner, timer_id,
    input  ready
  );
  modport sink (
    input  valid, command, now, interval, repeat_req, owner, timer_id,
    output ready
  );
endinterface

// ----- hdl/stt_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_res_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface stt_res_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [1:0]               status;
  logic [stt_pkg::ID_W-1:0] result_id;
  logic                     last;

  modport source (
    output valid, kind, status, result_id, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, result_id, last,
    output ready
  );
endinterface

// ----- hdl/stt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/stt_slot_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_slot_eval: expiry check for one slot
// Modular elapsed time against the interval, and the re-arm start time.
// ----------------------------------------------------------------------------
module stt_slot_eval #(
  parameter int TIME_BITS = stt_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] start_i,
  input  logic [TIME_BITS-1:0] interval_i,
  output logic                 due_o,
  output logic [TIME_BITS-1:0] start_next_o
);

  logic [TIME_BITS-1:0] elapsed;

  assign elapsed      = now_i - start_i;
  assign due_o        = (elapsed >= interval_i);
  assign start_next_o = start_i + interval_i;

endmodule

// ----- hdl/software_timer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table: timer slot table
// Set, kill and process commands over a table of timer slots.
// ----------------------------------------------------------------------------
// Set and kill are handled in the cycle they are accepted; the lowest free slot
// comes from the armed flags, which sit in flip-flops. Process walks the slot
// RAM one entry per cycle while no fired word waits on the result side (one
// read port, registered read). It keeps the command side busy until the scan
// and its done word are through; each armed, due slot of the command's owner
// gives one fired word, and a done word closes the scan. A new command is
// taken once the previous one has finished and the output register is free
// or being drained.
module software_timer_table #(
  parameter int SLOTS      = stt_pkg::SLOTS_DEF,
  parameter int TIME_BITS  = stt_pkg::TIME_BITS_DEF,
  parameter int OWNER_BITS = stt_pkg::OWNER_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_cmd_if.sink   cmd_i,
  stt_res_if.source res_o
);
  import stt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENT_W = 1 + 2 * TIME_BITS + OWNER_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [SLOTS-1:0]      armed_q, armed_d;
  logic [CNT_W-1:0]      rd_cnt_q, rd_cnt_d;
  logic                  e_valid_q, e_valid_d;
  logic [IDX_W-1:0]      e_idx_q, e_idx_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            kind_q, kind_d;
  logic [1:0]            status_q, status_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic                  last_q, last_d;
  logic                  out_load;
  logic                  can_load;
  logic                  accept;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [ENT_W-1:0]      ram_rdata;

  logic                  ent_repeat;
  logic [TIME_BITS-1:0]  ent_interval;
  logic [TIME_BITS-1:0]  ent_start;
  logic [OWNER_BITS-1:0] ent_owner;
  logic                  due;
  logic [TIME_BITS-1:0]  start_next;
  logic                  fire;
  logic                  stall;

  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [ID_W-1:0]       kill_m1;
  logic [IDX_W-1:0]      kill_idx;
  logic                  kill_ok;

  stt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign {ent_repeat, ent_interval, ent_start, ent_owner} = ram_rdata;

  stt_slot_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .now_i        (now_q),
    .start_i      (ent_start),
    .interval_i   (ent_interval),
    .due_o        (due),
    .start_next_o (start_next)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!armed_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign kill_m1  = cmd_i.timer_id - ID_W'(1);
  assign kill_idx = IDX_W'(kill_m1);
  assign kill_ok  = (cmd_i.timer_id != '0) && (int'(cmd_i.timer_id) <= SLOTS) &&
                    armed_q[kill_idx];

  assign can_load    = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && can_load;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign fire  = e_valid_q && armed_q[e_idx_q] && (ent_owner == owner_q) && due;
  assign stall = fire && !can_load;

  always_comb begin
    state_d   = state_q;
    armed_d   = armed_q;
    rd_cnt_d  = rd_cnt_q;
    e_valid_d = e_valid_q;
    e_idx_d   = e_idx_q;
    now_d     = now_q;
    owner_d   = owner_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    kind_d    = kind_q;
    status_d  = status_q;
    id_d      = id_q;
    last_d    = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_SET: begin
              out_load = 1'b1;
              kind_d   = KIND_SET;
              last_d   = 1'b1;
              if (free_found) begin
                armed_d[free_idx] = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = free_idx;
                ram_wdata = {cmd_i.repeat_req, cmd_i.interval, cmd_i.now, cmd_i.owner};
                status_d  = STS_OK;
                id_d      = ID_W'(free_idx) + ID_W'(1);
              end else begin
                status_d = STS_FULL;
                id_d     = '0;
              end
            end
            CMD_KILL: begin
              out_load = 1'b1;
              kind_d   = KIND_KILL;
              last_d   = 1'b1;
              if (kill_ok) begin
                armed_d[kill_idx] = 1'b0;
                status_d = STS_OK;
                id_d     = cmd_i.timer_id;
              end else begin
                status_d = STS_BAD_ID;
                id_d     = '0;
              end
            end
            CMD_PROCESS: begin
              state_d   = ST_SCAN;
              rd_cnt_d  = '0;
              e_valid_d = 1'b0;
              now_d     = cmd_i.now;
              owner_d   = cmd_i.owner;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (fire && can_load) begin
          out_load = 1'b1;
          kind_d   = KIND_FIRED;
          status_d = STS_OK;
          id_d     = ID_W'(e_idx_q) + ID_W'(1);
          last_d   = 1'b0;
          if (ent_repeat) begin
            ram_we    = 1'b1;
            ram_waddr = e_idx_q;
            ram_wdata = {ent_repeat, ent_interval, start_next, ent_owner};
          end else begin
            armed_d[e_idx_q] = 1'b0;
          end
        end
        if (!stall) begin
          if (rd_cnt_q != CNT_W'(SLOTS)) begin
            ram_re    = 1'b1;
            rd_cnt_d  = rd_cnt_q + CNT_W'(1);
            e_valid_d = 1'b1;
            e_idx_d   = rd_cnt_q[IDX_W-1:0];
          end else begin
            e_valid_d = 1'b0;
            if (!e_valid_q) begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (can_load) begin
          out_load = 1'b1;
          kind_d   = KIND_DONE;
          status_d = STS_OK;
          id_d     = '0;
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= '0;
      rd_cnt_q    <= '0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      rd_cnt_q    <= rd_cnt_d;
      e_valid_q   <= e_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_idx_q <= e_idx_d;
    now_q   <= now_d;
    owner_q <= owner_d;
    if (out_load) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      id_q     <= id_d;
      last_q   <= last_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.kind      = kind_q;
  assign res_o.status    = status_q;
  assign res_o.result_id = id_q;
  assign res_o.last      = last_q;

endmodule

// ----- sim/stt_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_reply_checker: timer table reply checker
// Watches the command and result channels of the timer table. Keeps its own
// copy of the slot table, works out the reply words of every accepted command
// and compares each accepted result word with the oldest one still owed.
// ----------------------------------------------------------------------------
module stt_reply_checker (
  input  logic clk_i,
  input  logic rst_ni,
  stt_cmd_if   cmd_mon,
  stt_res_if   res_mon,
  output int   fails_o,
  output int   pending_o,
  output int   words_o,
  output int   fired_o
);
  import stt_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int TW    = TIME_BITS_DEF;
  localparam int OW    = OWNER_BITS_DEF;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    logic [ID_W-1:0]   id;
    logic              last;
  } reply_t;

  reply_t          owed_replies[$];
  logic            armed    [SLOTS];
  logic            periodic [SLOTS];
  logic [TW-1:0]   period   [SLOTS];
  logic [TW-1:0]   started  [SLOTS];
  logic [OW-1:0]   holder   [SLOTS];

  initial begin
    fails_o   = 0;
    pending_o = 0;
    words_o   = 0;
    fired_o   = 0;
  end

  function automatic reply_t make_reply(kind_e k, status_e s, int id, logic l);
    reply_t r;
    r.kind   = k;
    r.status = s;
    r.id     = id[ID_W-1:0];
    r.last   = l;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fails_o++;
    if (fails_o <= 100)
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic table_apply(input logic [1:0] command, input logic [TW-1:0] now,
                             input logic [TW-1:0] interval, input logic repeat_req,
                             input logic [OW-1:0] owner, input logic [ID_W-1:0] timer_id);
    int            idx;
    bit            placed;
    logic [TW-1:0] elapsed;
    case (command)
      CMD_SET: begin
        placed = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !armed[i]) begin
            armed[i]    = 1'b1;
            periodic[i] = repeat_req;
            period[i]   = interval;
            started[i]  = now;
            holder[i]   = owner;
            owed_replies.push_back(make_reply(KIND_SET, STS_OK, i + 1, 1'b1));
            placed = 1'b1;
          end
        end
        if (!placed)
          owed_replies.push_back(make_reply(KIND_SET, STS_FULL, 0, 1'b1));
      end
      CMD_KILL: begin
        idx = int'(timer_id);
        if (idx >= 1 && idx <= SLOTS && armed[idx-1]) begin
          armed[idx-1] = 1'b0;
          owed_replies.push_back(make_reply(KIND_KILL, STS_OK, idx, 1'b1));
        end else begin
          owed_replies.push_back(make_reply(KIND_KILL, STS_BAD_ID, 0, 1'b1));
        end
      end
      CMD_PROCESS: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (armed[i] && holder[i] == owner) begin
            elapsed = now - started[i];
            if (elapsed >= period[i]) begin
              owed_replies.push_back(make_reply(KIND_FIRED, STS_OK, i + 1, 1'b0));
              if (periodic[i])
                started[i] = started[i] + period[i];
              else
                armed[i] = 1'b0;
            end
          end
        end
        owed_replies.push_back(make_reply(KIND_DONE, STS_OK, 0, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    reply_t want;
    if (owed_replies.size() == 0) begin
      report("word with nothing owed",
             32'({res_mon.kind, res_mon.status, res_mon.result_id, res_mon.last}), 32'd0);
    end else begin
      want = owed_replies.pop_front();
      words_o++;
      if (want.kind == KIND_FIRED) fired_o++;
      if (res_mon.kind !== want.kind)
        report("kind", 32'(res_mon.kind), 32'(want.kind));
      if (res_mon.status !== want.status)
        report("status", 32'(res_mon.status), 32'(want.status));
      if (res_mon.result_id !== want.id)
        report("result_id", 32'(res_mon.result_id), 32'(want.id));
      if (res_mon.last !== want.last)
        report("last", 32'(res_mon.last), 32'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) armed[i] = 1'b0;
      owed_replies.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) check_word();
      if (cmd_mon.valid && cmd_mon.ready)
        table_apply(cmd_mon.command, cmd_mon.now, cmd_mon.interval, cmd_mon.repeat_req,
                    cmd_mon.owner, cmd_mon.timer_id);
    end
    pending_o = owed_replies.size();
  end

endmodule

// ----- sim/tb_software_timer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_software_timer_table: timer table testbench
// Drives directed and random set, kill and process commands into the timer
// table under three sender/receiver idle mixes and one long result stall;
// the reply checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_software_timer_table;
  import stt_pkg::*;

  localparam int         TW           = TIME_BITS_DEF;
  localparam int         OW           = OWNER_BITS_DEF;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         DRAIN_CYCLES = 3 * (SLOTS_DEF + 2);
  localparam int         CYCLE_LIMIT  = 400000;

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          hold_on = 1'b0;
  int            src_idle_pct = 0;
  int            snk_idle_pct = 0;
  int            words_sent   = 0;
  int            cycle_cnt    = 0;
  logic [TW-1:0] tick;
  event          hold_start;

  int fails, pending, words, fired;

  stt_cmd_if cmd_if ();
  stt_res_if res_if ();

  software_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  stt_reply_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_mon   (cmd_if),
    .res_mon   (res_if),
    .fails_o   (fails),
    .pending_o (pending),
    .words_o   (words),
    .fired_o   (fired)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_cnt, pending);
      $display("software_timer_table test failed");
      $finish;
    end
  end

  // result side: random back-pressure, or a solid stall while hold_on is set
  always @(posedge clk_i) begin
    if (rst_ni)
      res_if.ready <= !hold_on && ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    forever begin
      @hold_start;
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  task automatic send_cmd(input logic [1:0] c, input logic [TW-1:0] t, input logic [TW-1:0] iv,
                          input logic rq, input logic [OW-1:0] ow, input logic [ID_W-1:0] id);
    if ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= c;
    cmd_if.now        <= t;
    cmd_if.interval   <= iv;
    cmd_if.repeat_req <= rq;
    cmd_if.owner      <= ow;
    cmd_if.timer_id   <= id;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  function automatic logic [OW-1:0] pick_owner();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'd7;
      4, 5:       return 8'd0;
      6:          return 8'hFF;
      7:          return 8'hA5;
      default:    return OW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_interval();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(3);
      2:       return $urandom;
      default: return $urandom_range(30, 1);
    endcase
  endfunction

  // mostly small forward steps so timers come due; now and then a jump
  task automatic run_phase(input int n);
    int            sent;
    int            pick;
    logic [1:0]    c;
    logic [ID_W-1:0] id;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(19))
        0:       tick = $urandom;
        1:       tick = 32'hFFFF_FFF0 + $urandom_range(15);
        default: tick = tick + $urandom_range(12);
      endcase
      pick = $urandom_range(99);
      if (pick < 36)      c = CMD_SET;
      else if (pick < 60) c = CMD_KILL;
      else if (pick < 95) c = CMD_PROCESS;
      else                c = CMD_UNUSED;
      case ($urandom_range(9))
        0:       id = '0;
        1:       id = ID_W'($urandom_range(31, 17));
        default: id = ID_W'($urandom_range(16, 1));
      endcase
      send_cmd(c, tick, pick_interval(), 1'($urandom_range(1)), pick_owner(), id);
      if (c != CMD_UNUSED) sent++;
    end
  endtask

  initial begin
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_SET;
    cmd_if.now        = '0;
    cmd_if.interval   = '0;
    cmd_if.repeat_req = 1'b0;
    cmd_if.owner      = '0;
    cmd_if.timer_id   = '0;
    res_if.ready      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 20;
    snk_idle_pct = 48;

    // empty table, bad kill, zero interval, full-range interval and time
    send_cmd(CMD_PROCESS, '0, '0, 1'b0, 8'd0, '0);
    send_cmd(CMD_KILL, '0, '0, 1'b0, 8'd0, '0);
    send_cmd(CMD_SET, '0, '0, 1'b0, 8'd0, '0);
    send_cmd(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, '0);
    send_cmd(CMD_PROCESS, '0, '0, 1'b0, 8'd0, '0);
    send_cmd(CMD_PROCESS, 32'hFFFF_FFFE, '0, 1'b0, 8'hFF, '0);
    send_cmd(CMD_KILL, '0, '0, 1'b0, 8'd0, 5'd2);
    // fill the table, overflow it, then fire every slot in one scan
    for (int i = 0; i < SLOTS_DEF; i++)
      send_cmd(CMD_SET, 32'h100, 32'd3, i[0], 8'd7, '0);
    send_cmd(CMD_SET, 32'h100, 32'd3, 1'b0, 8'd7, '0);
    send_cmd(CMD_KILL, '0, '0, 1'b0, 8'd0, 5'd31);
    send_cmd(CMD_KILL, '0, '0, 1'b0, 8'd0, 5'd17);
    send_cmd(CMD_PROCESS, 32'h103, '0, 1'b0, 8'd7, '0);
    send_cmd(CMD_UNUSED, '1, '1, 1'b1, 8'hFF, 5'd31);
    tick = 32'h103;

    run_phase(95);

    src_idle_pct = 48;
    snk_idle_pct = 20;
    run_phase(95);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    -> hold_start;
    run_phase(90);

    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d command words, checked %0d result words, %0d of them expiries",
             words_sent, words, fired);
    $display("idle mixes 20/48, 48/20 and none, plus one %0d-cycle result stall",
             HOLD_CYCLES);
    if (fails == 0) begin
      $display("software_timer_table test passed");
    end else begin
      $display("%0d mismatches", fails);
      $display("software_timer_table test failed");
    end
    $finish;
  end

endmodule
